@@ sv/zvc_pkg.sv @@
// types and constants shared by the varint codec modules
`timescale 1ns / 1ps
`default_nettype none
package zvc_pkg;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } op_t;

    typedef enum logic {
        KIND_BYTE  = 1'b0,
        KIND_VALUE = 1'b1
    } kind_t;

    typedef enum logic {
        BK_IDLE   = 1'b0,
        BK_ENCODE = 1'b1
    } back_state_t;

    typedef struct packed {
        op_t         opcode;
        logic        use_zigzag;
        logic        wide;
        logic [63:0] value;
        logic [7:0]  in_byte;
    } in_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  out_byte;
        logic [63:0] out_value;
        logic        last;
    } out_t;

    // one classified word waiting for the back end
    typedef struct packed {
        op_t         opcode;
        logic        use_zigzag;
        logic        wide;
        logic [63:0] data;
    } entry_t;

    localparam int unsigned GROUP_BITS  = 7;
    localparam logic [3:0]  BYTES_NARROW = 4'd5;
    localparam logic [3:0]  BYTES_WIDE   = 4'd10;
    localparam logic [31:0] NARROW_MASK  = 32'hFFFF_FFFF;

endpackage
`default_nettype wire

@@ sv/zigzag_varint_codec_core.sv @@
// top level of the base-128 varint codec with zigzag mapping
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+------------------------------------------
//  s_      | in        | s_valid / s_ready  | opcode, use_zigzag, wide, value, in_byte
//  m_      | out       | m_valid / m_ready  | kind, out_byte, out_value, last
//
// an encode word yields 1 to 10 output bytes, a decode word adds one input byte
// to its run; the back end's output register takes one result a cycle unless stalled
// a two-word queue lets the front accept while the back end is busy or stalled
// reset (aresetn low at a clock edge) empties the queue, clears the output
// register's valid and the decode accumulator, count and latched flags
// a stall on m_ready holds the result and, once the queue fills, drops s_ready
`timescale 1ns / 1ps
`default_nettype none
module zigzag_varint_codec_core (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire zvc_pkg::in_t   s_payload,
    output logic                m_valid,
    input  wire logic           m_ready,
    output zvc_pkg::out_t       m_payload
);

    // front to queue
    logic            q_push;
    zvc_pkg::entry_t q_entry;
    logic            q_full;

    // queue to back end
    logic            q_pop;
    logic            q_not_empty;
    zvc_pkg::entry_t q_head;

    // classify and map the incoming word
    zvc_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    // decouples front from back
    zvc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    // byte emission and value accumulation
    zvc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_not_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // a decoded value always closes its run
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.kind == zvc_pkg::KIND_VALUE) |-> m_payload.last)
        else $error("decoded value without last");

    // an encoded byte carries the continuation bit exactly when it is not last
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.kind == zvc_pkg::KIND_BYTE)
            |-> (m_payload.last == !m_payload.out_byte[7]))
        else $error("continuation bit disagrees with last");

    // never pop an empty queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_not_empty)
        else $error("pop from empty queue");

    // front stalls only when the queue holds words
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> q_not_empty)
        else $error("input stalled with empty queue");

endmodule
`default_nettype wire

@@ sv/zvc_front.sv @@
// front end: accepts input words, masks and zigzag-maps encode values
`timescale 1ns / 1ps
`default_nettype none
module zvc_front (
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire zvc_pkg::in_t   s_payload,
    input  wire logic           q_full,
    output logic                q_push,
    output zvc_pkg::entry_t     q_entry
);

    logic [63:0] masked;
    logic        sign;
    logic [63:0] mapped;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        masked = s_payload.wide ? s_payload.value
                                : {32'b0, s_payload.value[31:0] & zvc_pkg::NARROW_MASK};
        sign   = s_payload.wide ? masked[63] : masked[31];
        mapped = masked;
        if (s_payload.use_zigzag) begin
            mapped = (masked << 1) ^ {64{sign}};
            if (!s_payload.wide) begin
                mapped[63:32] = 32'b0;
            end
        end
        q_entry.opcode     = s_payload.opcode;
        q_entry.use_zigzag = s_payload.use_zigzag;
        q_entry.wide       = s_payload.wide;
        unique case (s_payload.opcode)
            zvc_pkg::OP_ENCODE: q_entry.data = mapped;
            zvc_pkg::OP_DECODE: q_entry.data = {56'b0, s_payload.in_byte};
            default:            q_entry.data = mapped;
        endcase
    end

endmodule
`default_nettype wire

@@ sv/zvc_queue.sv @@
// two-entry queue between front and back ends
`timescale 1ns / 1ps
`default_nettype none
module zvc_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire zvc_pkg::entry_t push_entry,
    input  wire logic            pop,
    output logic                 full,
    output logic                 not_empty,
    output zvc_pkg::entry_t      head
);

    zvc_pkg::entry_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

@@ sv/zvc_back.sv @@
// back end: emits encoded bytes, accumulates decode bytes, output register
`timescale 1ns / 1ps
`default_nettype none
module zvc_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            q_valid,
    input  wire zvc_pkg::entry_t q_head,
    output logic                 q_pop,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output zvc_pkg::out_t        m_payload
);

    zvc_pkg::back_state_t state_reg, state_next;
    logic          m_valid_reg, m_valid_next;
    zvc_pkg::out_t m_payload_reg, m_payload_next;
    logic [63:0]   enc_n_reg, enc_n_next;
    logic [63:0]   acc_reg, acc_next;
    logic [3:0]    bc_reg, bc_next;
    logic          lzz_reg, lzz_next;
    logic          lwide_reg, lwide_next;

    logic          can_load;
    logic [63:0]   enc_src;
    logic          enc_more;
    logic [7:0]    enc_byte;
    logic          zz_eff, wide_eff;
    logic [3:0]    limit, bc_eff, bc_inc;
    logic [6:0]    shift_amt;
    logic [63:0]   mask, acc_new, dec_v;
    logic          dec_done;

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;
    assign can_load  = !m_valid_reg || m_ready;

    // encode byte from either the queue head or the running shift register
    always_comb begin
        enc_src  = (state_reg == zvc_pkg::BK_ENCODE) ? enc_n_reg : q_head.data;
        enc_more = |enc_src[63:zvc_pkg::GROUP_BITS];
        enc_byte = enc_more ? {1'b1, enc_src[6:0]} : enc_src[7:0];
    end

    // decode datapath
    always_comb begin
        zz_eff    = (bc_reg == 4'd0) ? q_head.use_zigzag : lzz_reg;
        wide_eff  = (bc_reg == 4'd0) ? q_head.wide : lwide_reg;
        limit     = wide_eff ? zvc_pkg::BYTES_WIDE : zvc_pkg::BYTES_NARROW;
        mask      = wide_eff ? {64{1'b1}} : {32'b0, zvc_pkg::NARROW_MASK};
        bc_eff    = (bc_reg >= limit) ? (limit - 4'd1) : bc_reg;
        bc_inc    = bc_eff + 4'd1;
        shift_amt = {bc_eff, 3'b0} - {3'b0, bc_eff};
        acc_new   = (acc_reg | ({57'b0, q_head.data[6:0]} << shift_amt)) & mask;
        dec_done  = !(q_head.data[7] && (bc_inc < limit));
        dec_v     = acc_new;
        if (zz_eff) begin
            dec_v = ((acc_new >> 1) ^ {64{acc_new[0]}}) & mask;
            if (!wide_eff && dec_v[31]) begin
                dec_v[63:32] = 32'hFFFF_FFFF;
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;
        enc_n_next     = enc_n_reg;
        acc_next       = acc_reg;
        bc_next        = bc_reg;
        lzz_next       = lzz_reg;
        lwide_next     = lwide_reg;
        q_pop          = 1'b0;
        unique case (state_reg)
            zvc_pkg::BK_IDLE: begin
                if (q_valid && can_load) begin
                    q_pop = 1'b1;
                    if (q_head.opcode == zvc_pkg::OP_ENCODE) begin
                        m_valid_next             = 1'b1;
                        m_payload_next.kind      = zvc_pkg::KIND_BYTE;
                        m_payload_next.out_byte  = enc_byte;
                        m_payload_next.out_value = 64'b0;
                        m_payload_next.last      = !enc_more;
                        enc_n_next               = enc_src >> zvc_pkg::GROUP_BITS;
                        if (enc_more) begin
                            state_next = zvc_pkg::BK_ENCODE;
                        end
                    end else begin
                        lzz_next   = zz_eff;
                        lwide_next = wide_eff;
                        if (dec_done) begin
                            m_valid_next             = 1'b1;
                            m_payload_next.kind      = zvc_pkg::KIND_VALUE;
                            m_payload_next.out_byte  = 8'b0;
                            m_payload_next.out_value = dec_v;
                            m_payload_next.last      = 1'b1;
                            acc_next                 = 64'b0;
                            bc_next                  = 4'd0;
                        end else begin
                            acc_next = acc_new;
                            bc_next  = bc_inc;
                        end
                    end
                end
            end
            zvc_pkg::BK_ENCODE: begin
                if (can_load) begin
                    m_valid_next             = 1'b1;
                    m_payload_next.kind      = zvc_pkg::KIND_BYTE;
                    m_payload_next.out_byte  = enc_byte;
                    m_payload_next.out_value = 64'b0;
                    m_payload_next.last      = !enc_more;
                    enc_n_next               = enc_src >> zvc_pkg::GROUP_BITS;
                    if (!enc_more) begin
                        state_next = zvc_pkg::BK_IDLE;
                    end
                end
            end
            default: state_next = zvc_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= zvc_pkg::BK_IDLE;
            m_valid_reg <= 1'b0;
            acc_reg     <= 64'b0;
            bc_reg      <= 4'd0;
            lzz_reg     <= 1'b0;
            lwide_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            acc_reg     <= acc_next;
            bc_reg      <= bc_next;
            lzz_reg     <= lzz_next;
            lwide_reg   <= lwide_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_payload_reg <= m_payload_next;
        enc_n_reg     <= enc_n_next;
    end

endmodule
`default_nettype wire
